/* hdl/tcap_pkg.sv */
// package for the trace capture block: ring geometry, event codes, item types
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package tcap_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int POST_W     = SLOT_W + 1;
  localparam int HALF_DEPTH = RING_DEPTH / 2;
  localparam int IDX_EXT_W  = 17;

  localparam logic [3:0] CODE_RD_ENTER = 4'd0;
  localparam logic [3:0] CODE_RD_EXIT  = 4'd1;
  localparam logic [3:0] CODE_WR_ENTER = 4'd2;
  localparam logic [3:0] CODE_WR_EXIT  = 4'd3;

  localparam logic REQ_LOG  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam int   CFG_AW           = 3;
  localparam logic REG_TRACE_ENABLE = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  event_code;
    logic [63:0] time_ns;
    logic        arm_trigger;
    logic [9:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_runtime;
    logic [31:0] write_runtime;
    logic [31:0] total_runtime;
    logic [31:0] read_max;
    logic [31:0] write_max;
    logic [31:0] total_max;
    logic        is_frozen;
    logic        export_ready;
    logic [9:0]  trigger_slot;
    logic [31:0] events_logged;
    logic [63:0] entry_time;
    logic [3:0]  entry_event;
  } out_item_t;

  typedef struct packed {
    logic [31:0] read_runtime;
    logic [31:0] write_runtime;
    logic [31:0] total_runtime;
    logic [31:0] read_max;
    logic [31:0] write_max;
    logic [31:0] total_max;
    logic        is_frozen;
    logic        export_ready;
    logic [9:0]  trigger_slot;
    logic [31:0] events_logged;
  } stat_t;

  typedef struct packed {
    logic [63:0] time_ns;
    logic [3:0]  event_code;
  } ring_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    ring_entry_t       wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } ring_ctl_t;

endpackage

/* hdl/tcap_ring.sv */
// trace ring memory: one write port, one registered read port
// depends on tcap_pkg
`timescale 1ns / 1ps

module tcap_ring (
  input  logic                 clk,
  input  tcap_pkg::ring_ctl_t  ctl,
  output tcap_pkg::ring_entry_t rd_data
);
  import tcap_pkg::*;

  ring_entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

/* hdl/tcap_state.sv */
// phase runtime statistics, trigger and freeze control, ring write pointer
// depends on tcap_pkg; drives the ring control of tcap_ring
`timescale 1ns / 1ps

module tcap_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  tcap_pkg::in_item_t  item,
  input  logic                trace_en,
  output tcap_pkg::stat_t     stat,
  output tcap_pkg::ring_ctl_t ring_ctl,
  output logic                rd_hit
);
  import tcap_pkg::*;

  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [63:0]       rd_start_r, rd_start_nxt;
  logic [63:0]       wr_start_r, wr_start_nxt;
  logic [31:0]       rd_last_r, rd_last_nxt;
  logic [31:0]       wr_last_r, wr_last_nxt;
  logic [31:0]       tot_last_r, tot_last_nxt;
  logic [31:0]       rd_peak_r, rd_peak_nxt;
  logic [31:0]       wr_peak_r, wr_peak_nxt;
  logic [31:0]       tot_peak_r, tot_peak_nxt;
  logic              armed_r, armed_nxt;
  logic [POST_W-1:0] post_r, post_nxt;
  logic [SLOT_W-1:0] trig_r, trig_nxt;
  logic              frozen_r, frozen_nxt;
  logic              export_r, export_nxt;
  logic [31:0]       evcnt_r, evcnt_nxt;

  logic              log_en;
  logic [63:0]       rd_diff, wr_diff;
  logic [31:0]       rd_run, wr_run, tot_run;
  logic [SLOT_W-1:0] ws_prev;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [SLOT_W-1:0] rd_slot;

  assign log_en  = accept && (item.req_type == REQ_LOG) && trace_en && !frozen_r;
  assign rd_diff = item.time_ns - rd_start_r;
  assign wr_diff = item.time_ns - wr_start_r;
  assign rd_run  = rd_diff[31:0];
  assign wr_run  = wr_diff[31:0];
  assign tot_run = rd_last_r + wr_run;
  assign ws_prev = (ws_r == '0) ? SLOT_W'(RING_DEPTH - 1) : ws_r - 1'b1;
  assign idx_ext = IDX_EXT_W'(item.read_index);
  assign rd_slot = idx_ext[SLOT_W-1:0];

  always_comb begin
    ws_nxt       = ws_r;
    wrapped_nxt  = wrapped_r;
    rd_start_nxt = rd_start_r;
    wr_start_nxt = wr_start_r;
    rd_last_nxt  = rd_last_r;
    wr_last_nxt  = wr_last_r;
    tot_last_nxt = tot_last_r;
    rd_peak_nxt  = rd_peak_r;
    wr_peak_nxt  = wr_peak_r;
    tot_peak_nxt = tot_peak_r;
    armed_nxt    = armed_r;
    post_nxt     = post_r;
    trig_nxt     = trig_r;
    frozen_nxt   = frozen_r;
    export_nxt   = export_r;
    evcnt_nxt    = evcnt_r;
    if (log_en) begin
      case (item.event_code)
        CODE_RD_ENTER: begin
          rd_start_nxt = item.time_ns;
        end
        CODE_RD_EXIT: begin
          rd_last_nxt = rd_run;
          if (rd_run > rd_peak_r) begin
            rd_peak_nxt = rd_run;
          end
        end
        CODE_WR_ENTER: begin
          wr_start_nxt = item.time_ns;
        end
        CODE_WR_EXIT: begin
          wr_last_nxt  = wr_run;
          tot_last_nxt = tot_run;
          if (wr_run > wr_peak_r) begin
            wr_peak_nxt = wr_run;
          end
          if (tot_run > tot_peak_r) begin
            tot_peak_nxt = tot_run;
          end
        end
        default: begin
        end
      endcase
      if (armed_r) begin
        if (post_r == POST_W'(HALF_DEPTH)) begin
          trig_nxt = ws_prev;
        end
        if (post_r != '0) begin
          post_nxt = post_r - 1'b1;
          if (post_r == POST_W'(1)) begin
            frozen_nxt = 1'b1;
            export_nxt = 1'b1;
          end
        end
      end
      if (ws_r == SLOT_W'(RING_DEPTH - 1)) begin
        ws_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        ws_nxt = ws_r + 1'b1;
      end
      evcnt_nxt = evcnt_r + 32'd1;
      if (item.arm_trigger && !armed_r) begin
        armed_nxt = 1'b1;
        post_nxt  = POST_W'(HALF_DEPTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r       <= '0;
      wrapped_r  <= 1'b0;
      rd_start_r <= '0;
      wr_start_r <= '0;
      rd_last_r  <= '0;
      wr_last_r  <= '0;
      tot_last_r <= '0;
      rd_peak_r  <= '0;
      wr_peak_r  <= '0;
      tot_peak_r <= '0;
      armed_r    <= 1'b0;
      post_r     <= '0;
      trig_r     <= '0;
      frozen_r   <= 1'b0;
      export_r   <= 1'b0;
      evcnt_r    <= '0;
    end else begin
      ws_r       <= ws_nxt;
      wrapped_r  <= wrapped_nxt;
      rd_start_r <= rd_start_nxt;
      wr_start_r <= wr_start_nxt;
      rd_last_r  <= rd_last_nxt;
      wr_last_r  <= wr_last_nxt;
      tot_last_r <= tot_last_nxt;
      rd_peak_r  <= rd_peak_nxt;
      wr_peak_r  <= wr_peak_nxt;
      tot_peak_r <= tot_peak_nxt;
      armed_r    <= armed_nxt;
      post_r     <= post_nxt;
      trig_r     <= trig_nxt;
      frozen_r   <= frozen_nxt;
      export_r   <= export_nxt;
      evcnt_r    <= evcnt_nxt;
    end
  end

  // slots beyond the write pointer before the first wrap still read as zero
  assign rd_hit = (item.req_type == REQ_READ) && (idx_ext < IDX_EXT_W'(RING_DEPTH))
                  && (wrapped_r || (rd_slot < ws_r));

  assign ring_ctl.wr_en              = log_en;
  assign ring_ctl.wr_addr            = ws_r;
  assign ring_ctl.wr_data.time_ns    = item.time_ns;
  assign ring_ctl.wr_data.event_code = item.event_code;
  assign ring_ctl.rd_en              = accept;
  assign ring_ctl.rd_addr            = rd_slot;

  assign stat.read_runtime  = rd_last_nxt;
  assign stat.write_runtime = wr_last_nxt;
  assign stat.total_runtime = tot_last_nxt;
  assign stat.read_max      = rd_peak_nxt;
  assign stat.write_max     = wr_peak_nxt;
  assign stat.total_max     = tot_peak_nxt;
  assign stat.is_frozen     = frozen_nxt;
  assign stat.export_ready  = export_nxt;
  assign stat.trigger_slot  = 10'(trig_nxt);
  assign stat.events_logged = evcnt_nxt;

endmodule

/* hdl/trace_capture_with_trigger_top.sv */
// top level of the trace capture block: config register, two-stage result pipe
// depends on tcap_pkg, tcap_state, tcap_ring
`timescale 1ns / 1ps

// Trace capture with post-trigger freeze.
// Input channel (in_valid / in_stall / in_data): one item is either a log
// request (event code plus timestamp, optional arm) or a read of one ring slot.
// Result channel (out_valid / out_stall / out_data): exactly one item per input
// item, in order, carrying the runtime statistics and freeze status after the
// request, plus the ring entry for a read (zero for a log request).
// Throughput is one item per cycle while in_stall is low. From acceptance to
// out_valid an item passes the first register stage, which holds the ring read
// data and the statistics, and then the second, the output register.
// When the receiver stalls, the output holds and one more item is taken into
// the first stage; in_stall rises only when both stages are full and stalled.
// Reset (rst_n low, synchronous) clears all statistics, the trigger, the
// freeze and the write pointer, and sets trace_enable. The ring needs no
// clearing pass: slots not yet written since reset read as zero.
// trace_enable lives at byte address 0 of the APB port (pready always high);
// write it only while no item is in flight.

module trace_capture_with_trigger_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tcap_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tcap_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcap_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tcap_pkg::*;

  logic        trace_en_r;
  logic        accept;
  logic        s1_move;
  stat_t       stat;
  ring_ctl_t   ring_ctl;
  ring_entry_t rd_data;
  logic        rd_hit;

  logic        s1_valid_r;
  stat_t       s1_stat_r;
  logic        s1_hit_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRACE_ENABLE) ? {31'd0, trace_en_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_en_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TRACE_ENABLE)) begin
      trace_en_r <= pwdata[0];
    end
  end

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  tcap_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .trace_en (trace_en_r),
    .stat     (stat),
    .ring_ctl (ring_ctl),
    .rd_hit   (rd_hit)
  );

  tcap_ring u_ring (
    .clk     (clk),
    .ctl     (ring_ctl),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stat_r <= stat;
      s1_hit_r  <= rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.read_runtime  <= s1_stat_r.read_runtime;
      out_data_r.write_runtime <= s1_stat_r.write_runtime;
      out_data_r.total_runtime <= s1_stat_r.total_runtime;
      out_data_r.read_max      <= s1_stat_r.read_max;
      out_data_r.write_max     <= s1_stat_r.write_max;
      out_data_r.total_max     <= s1_stat_r.total_max;
      out_data_r.is_frozen     <= s1_stat_r.is_frozen;
      out_data_r.export_ready  <= s1_stat_r.export_ready;
      out_data_r.trigger_slot  <= s1_stat_r.trigger_slot;
      out_data_r.events_logged <= s1_stat_r.events_logged;
      out_data_r.entry_time    <= s1_hit_r ? rd_data.time_ns : 64'd0;
      out_data_r.entry_event   <= s1_hit_r ? rd_data.event_code : 4'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/tcap_checker.sv */
// port-level checks for the trace capture top level, attached by bind
// depends on tcap_pkg and trace_capture_with_trigger_top
`timescale 1ns / 1ps

module tcap_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input tcap_pkg::out_item_t         out_data
);
  import tcap_pkg::*;

  logic seen_frozen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_frozen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_data.is_frozen) begin
      seen_frozen_r <= 1'b1;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no unfreeze
  a_freeze_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_frozen_r |-> out_data.is_frozen)
    else $error("freeze dropped");

  a_export_with_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.export_ready == out_data.is_frozen))
    else $error("export flag differs from freeze");

  // input back-pressure only with a result waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // event count holds once frozen
  a_read_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && seen_frozen_r |=>
      !out_valid || (out_data.events_logged == $past(out_data.events_logged)))
    else $error("event count moved while frozen");

endmodule

bind trace_capture_with_trigger_top tcap_checker u_tcap_checker (.*);

/* dv/tb_trace_capture_with_trigger_top.sv */
// self-checking testbench for trace_capture_with_trigger_top: predicts every result item
// from its own copy of the ring, runtime statistics and trigger state; depends on tcap_pkg
`timescale 1ns / 1ps

module tb_trace_capture_with_trigger_top;
  import tcap_pkg::*;

  localparam int LIMIT = 3000;
  localparam logic [3:0] CODE_PLAIN_LO = 4'd4;
  localparam logic [3:0] CODE_PLAIN_HI = 4'd15;
  localparam logic [CFG_AW-1:0] ADDR_TRACE_ENABLE = CFG_AW'(4 * REG_TRACE_ENABLE);

  class capture_model;
    logic [63:0]       ring_time [RING_DEPTH];
    logic [3:0]        ring_code [RING_DEPTH];
    logic [SLOT_W-1:0] wr_slot;
    logic [63:0]       rd_start, wr_start;
    logic [31:0]       rd_last, wr_last, tot_last, rd_peak, wr_peak, tot_peak;
    bit                armed, frozen, export_pend, trace_on;
    logic [POST_W-1:0] post_left;
    logic [SLOT_W-1:0] trig_slot;
    logic [31:0]       logged;
    out_item_t         status_due[$];
    int                fault_count;
    int                seen;

    function new();
      foreach (ring_time[i]) begin
        ring_time[i] = '0;
        ring_code[i] = '0;
      end
      wr_slot = '0;
      rd_start = '0;
      wr_start = '0;
      rd_last = '0;
      wr_last = '0;
      tot_last = '0;
      rd_peak = '0;
      wr_peak = '0;
      tot_peak = '0;
      armed = 1'b0;
      frozen = 1'b0;
      export_pend = 1'b0;
      trace_on = 1'b1;
      post_left = '0;
      trig_slot = '0;
      logged = '0;
      fault_count = 0;
      seen = 0;
    endfunction

    function void report_mismatch(string msg);
      $display("mismatch at result %0d: %s", seen, msg);
      fault_count++;
    endfunction

    function int pending_count();
      return status_due.size();
    endfunction

    function void note_request(in_item_t it);
      out_item_t   r;
      logic [63:0] diff;
      logic [63:0] etime;
      logic [3:0]  ecode;
      etime = '0;
      ecode = '0;
      if (it.req_type == REQ_LOG) begin
        if (trace_on && !frozen) begin
          case (it.event_code)
            CODE_RD_ENTER: rd_start = it.time_ns;
            CODE_RD_EXIT: begin
              diff = it.time_ns - rd_start;
              rd_last = diff[31:0];
              if (rd_last > rd_peak) rd_peak = rd_last;
            end
            CODE_WR_ENTER: wr_start = it.time_ns;
            CODE_WR_EXIT: begin
              diff = it.time_ns - wr_start;
              wr_last = diff[31:0];
              if (wr_last > wr_peak) wr_peak = wr_last;
              tot_last = rd_last + wr_last;
              if (tot_last > tot_peak) tot_peak = tot_last;
            end
            default: ;
          endcase
          ring_time[wr_slot] = it.time_ns;
          ring_code[wr_slot] = it.event_code;
          if (armed) begin
            if (post_left == POST_W'(HALF_DEPTH)) trig_slot = wr_slot - 1'b1;
            if (post_left != '0) begin
              post_left = post_left - 1'b1;
              if (post_left == '0) begin
                frozen = 1'b1;
                export_pend = 1'b1;
              end
            end
          end
          wr_slot = wr_slot + 1'b1;
          logged = logged + 32'd1;
          if (it.arm_trigger && !armed) begin
            armed = 1'b1;
            post_left = POST_W'(HALF_DEPTH);
          end
        end
      end else begin
        etime = ring_time[it.read_index];
        ecode = ring_code[it.read_index];
      end
      r.read_runtime  = rd_last;
      r.write_runtime = wr_last;
      r.total_runtime = tot_last;
      r.read_max      = rd_peak;
      r.write_max     = wr_peak;
      r.total_max     = tot_peak;
      r.is_frozen     = frozen;
      r.export_ready  = export_pend;
      r.trigger_slot  = trig_slot;
      r.events_logged = logged;
      r.entry_time    = etime;
      r.entry_event   = ecode;
      status_due.push_back(r);
    endfunction

    function void cmp_field(string nm, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", nm, got, want));
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (status_due.size() == 0) begin
        report_mismatch("result item with nothing expected");
        return;
      end
      want = status_due.pop_front();
      cmp_field("read_runtime", got.read_runtime, want.read_runtime);
      cmp_field("write_runtime", got.write_runtime, want.write_runtime);
      cmp_field("total_runtime", got.total_runtime, want.total_runtime);
      cmp_field("read_max", got.read_max, want.read_max);
      cmp_field("write_max", got.write_max, want.write_max);
      cmp_field("total_max", got.total_max, want.total_max);
      cmp_field("is_frozen", got.is_frozen, want.is_frozen);
      cmp_field("export_ready", got.export_ready, want.export_ready);
      cmp_field("trigger_slot", got.trigger_slot, want.trigger_slot);
      cmp_field("events_logged", got.events_logged, want.events_logged);
      cmp_field("entry_time", got.entry_time, want.entry_time);
      cmp_field("entry_event", got.entry_event, want.entry_event);
      seen++;
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  capture_model model;
  bit           calm;
  int           logs_sent;
  int           idle_cycles;
  logic [63:0]  stamp;

  trace_capture_with_trigger_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [63:0] pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 64'd0;
    if (r < 75) return 64'($urandom_range(1, 5000));
    if (r < 90) return {32'd0, $urandom};
    return {$urandom, $urandom};
  endfunction

  function automatic bit roll_arm(bit ok);
    return ok && ($urandom_range(0, 7) == 0);
  endfunction

  // receiver stall pattern
  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = calm ? 0 : pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) model.note_request(in_data);
      if (out_valid && !out_stall) model.check_status(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_item(in_item_t it);
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic emit_log(logic [3:0] code, logic [63:0] t, bit arm);
    in_item_t it;
    it.req_type    = REQ_LOG;
    it.event_code  = code;
    it.time_ns     = t;
    it.arm_trigger = arm;
    it.read_index  = SLOT_W'($urandom_range(0, RING_DEPTH - 1));
    logs_sent++;
    push_item(it);
  endtask

  task automatic emit_read(int idx);
    in_item_t it;
    it.req_type    = REQ_READ;
    it.event_code  = 4'($urandom_range(0, 15));
    it.time_ns     = {$urandom, $urandom};
    it.arm_trigger = 1'($urandom_range(0, 1));
    it.read_index  = SLOT_W'(idx);
    push_item(it);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending_count() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_enable(bit v);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TRACE_ENABLE;
    pwdata  <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'd0, v})
      model.report_mismatch($sformatf("trace_enable reads %0h after writing %0d", got, v));
    model.trace_on = v;
  endtask

  // one enter/exit pair with optional plain markers in between
  task automatic phase_pair(logic [3:0] enter_code, logic [3:0] exit_code, bit arm_ok);
    logic [63:0] t0;
    logic [63:0] span;
    t0   = stamp;
    span = pick_span();
    emit_log(enter_code, t0, roll_arm(arm_ok));
    repeat ($urandom_range(0, 2))
      emit_log(4'($urandom_range(CODE_PLAIN_LO, CODE_PLAIN_HI)), t0 + $urandom_range(0, 7),
               roll_arm(arm_ok));
    emit_log(exit_code, t0 + span, roll_arm(arm_ok));
    stamp = t0 + span + $urandom_range(1, 100);
  endtask

  task automatic traffic(int log_goal, bit arm_ok);
    int start;
    int pick;
    start = logs_sent;
    while (logs_sent - start < log_goal) begin
      if (!calm && $urandom_range(0, 39) == 0) calm = 1'b1;
      else if (calm && $urandom_range(0, 9) == 0) calm = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        phase_pair(CODE_RD_ENTER, CODE_RD_EXIT, arm_ok);
      end else if (pick < 65) begin
        phase_pair(CODE_WR_ENTER, CODE_WR_EXIT, arm_ok);
      end else if (pick < 80) begin
        emit_read($urandom_range(0, RING_DEPTH - 1));
      end else if (pick < 90) begin
        emit_log(4'($urandom_range(CODE_PLAIN_LO, CODE_PLAIN_HI)), stamp, roll_arm(arm_ok));
        stamp = stamp + $urandom_range(1, 50);
      end else begin
        emit_log(4'($urandom_range(0, 15)), {$urandom, $urandom}, roll_arm(arm_ok));
      end
    end
  endtask

  task automatic mixed_burst(int n);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) emit_read($urandom_range(0, RING_DEPTH - 1));
      else emit_log(4'($urandom_range(0, 15)), {$urandom, $urandom}, 1'b1);
    end
  endtask

  initial begin
    model     = new();
    calm      = 1'b0;
    logs_sent = 0;
    stamp     = 64'd1000;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_enable(1'b1);

    // directed: unwritten slots, exits without enter, wrap and truncation of runtimes
    emit_read(0);
    emit_read(RING_DEPTH - 1);
    emit_log(CODE_RD_EXIT, 64'd5, 1'b0);
    emit_log(CODE_WR_EXIT, '1, 1'b0);
    emit_log(CODE_RD_ENTER, 64'd100, 1'b0);
    emit_log(CODE_RD_EXIT, 64'd100, 1'b0);
    emit_log(CODE_RD_ENTER, 64'h0000_0001_0000_0000, 1'b0);
    emit_log(CODE_RD_EXIT, 64'h0000_0002_0000_0003, 1'b0);
    emit_log(CODE_WR_ENTER, 64'd1000, 1'b0);
    emit_log(CODE_WR_EXIT, 64'd500, 1'b0);
    emit_log(CODE_RD_ENTER, '1, 1'b0);
    emit_log(CODE_RD_EXIT, 64'd0, 1'b0);
    emit_log(CODE_WR_ENTER, 64'h0123_4567_89ab_cdef, 1'b0);
    emit_log(CODE_WR_EXIT, 64'h0123_4567_89ab_cdef + 64'h7fff_ffff, 1'b0);
    emit_log(CODE_PLAIN_LO, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    emit_log(CODE_PLAIN_HI, 64'h5555_5555_5555_5555, 1'b0);
    emit_read(0);
    emit_read(1);
    emit_read(13);
    emit_read(14);
    emit_read(RING_DEPTH - 1);

    // disabled: logs and arms ignored, reads still served
    quiesce();
    set_enable(1'b0);
    emit_log(CODE_RD_ENTER, 64'd7, 1'b1);
    emit_log(CODE_WR_EXIT, 64'd99, 1'b1);
    emit_read(2);
    emit_log(CODE_PLAIN_HI, '1, 1'b1);
    emit_read(RING_DEPTH - 1);
    emit_read(0);
    quiesce();
    set_enable(1'b1);

    // long unarmed run, fills more than half of the ring
    traffic(540, 1'b0);
    quiesce();
    set_enable(1'b0);
    mixed_burst(8);
    quiesce();
    set_enable(1'b1);

    // arm, then run past the freeze point
    emit_log(CODE_PLAIN_LO, stamp, 1'b1);
    traffic(HALF_DEPTH + 10, 1'b1);

    // frozen: reads change nothing, logs and arms ignored
    quiesce();
    set_enable(1'b0);
    mixed_burst(8);
    quiesce();
    set_enable(1'b1);
    mixed_burst(30);

    quiesce();
    repeat (2) @(posedge clk);
    if (model.fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
